FILE: src/pts_pkg.sv
// shared types and constants for the task scheduler
package pts_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_INIT = 3'd1;
  localparam logic [2:0] ST_NULL_ID  = 3'd2;
  localparam logic [2:0] ST_PERIOD   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] REG_ENABLED    = 2'd0;
  localparam logic [1:0] REG_MAX_PERIOD = 2'd1;
  localparam logic [1:0] REG_WRAP_LIMIT = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [7:0]  prio;
    logic        periodic;
    logic        ready;
  } slot_t;

  // start and result of the shared remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic        zero_rem;
  } mod_rsp_t;

endpackage

FILE: src/priority_tick_task_scheduler_core.sv
// top level: task table, sequencer and configuration registers
// Usage: pulse start with action/task_id/period/priority_req/periodic while busy
// is low. The block raises busy and walks the task table one entry at a time.
// Exactly one result per transaction appears for one cycle with out_valid high.
// Flow: create goes straight to the done state; delete and dispatch scan the
// table and may remove entries; tick runs each entry with a nonzero period through
// the 32-step bit-serial remainder unit shared by all entries. busy is already
// low in the strobe cycle, so a new transaction can be taken at the edge that
// ends it.
// Configuration: APB-style, enabled at 0x0, max_period at 0x4, tick_wrap_limit at
// 0x8; pready is always high; write it only while busy is low.
// Reset (rst_n low, synchronous) empties the table, sets the tick counter to 1,
// clears enabled, sets max_period to its maximum and tick_wrap_limit to 0xFFFFFFFE.
// The receiver cannot stall: results must be taken in their strobe cycle.
// Table entries are flip-flops; entries past the count never affect a result.
module priority_tick_task_scheduler_core #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_priority_req,
  input  logic        in_periodic,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_run_valid,
  output logic [7:0]  out_run_task_id,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DEL, S_TICK_START, S_TICK_WAIT, S_DISP, S_DONE
  } state_t;

  state_t state_r;
  pts_pkg::slot_t table_r [TABLE_DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   tick_r;
  logic          enabled_r;
  logic [15:0]   max_period_r;
  logic [31:0]   wrap_r;
  logic [7:0]    del_id_r;
  logic          found_r;
  logic [IW-1:0] best_r;
  logic [7:0]    best_prio_r;
  logic [2:0]    status_r;
  logic          run_valid_r;
  logic [7:0]    run_id_r;
  logic          out_valid_r;

  pts_pkg::mod_req_t mreq;
  pts_pkg::mod_rsp_t mrsp;

  logic [IW-1:0] idx;
  logic [IW-1:0] last;
  logic          cfg_wr;
  logic [1:0]    reg_sel;

  assign idx  = idx_r[IW-1:0];
  assign last = IW'(count_r - CW'(1));
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel = cfg_paddr[3:2];

  pts_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  always_comb begin
    mreq.start    = (state_r == S_TICK_START);
    mreq.dividend = tick_r;
    mreq.divisor  = table_r[idx].period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      tick_r       <= 32'd1;
      enabled_r    <= 1'b0;
      max_period_r <= 16'hFFFF;
      wrap_r       <= 32'hFFFF_FFFE;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (reg_sel)
          pts_pkg::REG_ENABLED:    enabled_r    <= cfg_pwdata[0];
          pts_pkg::REG_MAX_PERIOD: max_period_r <= cfg_pwdata[15:0];
          pts_pkg::REG_WRAP_LIMIT: wrap_r       <= cfg_pwdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            status_r    <= pts_pkg::ST_OK;
            run_valid_r <= 1'b0;
            run_id_r    <= '0;
            idx_r       <= '0;
            found_r     <= 1'b0;
            del_id_r    <= in_task_id;
            state_r     <= S_DONE;
            case (pts_pkg::action_t'(in_action))
              pts_pkg::ACT_CREATE: begin
                if (!enabled_r) status_r <= pts_pkg::ST_NOT_INIT;
                else if (in_task_id == '0) status_r <= pts_pkg::ST_NULL_ID;
                else if (in_period > max_period_r) status_r <= pts_pkg::ST_PERIOD;
                else if (count_r >= DEPTH_C) status_r <= pts_pkg::ST_FULL;
                else begin
                  table_r[count_r[IW-1:0]] <= '{id: in_task_id, period: in_period,
                    prio: in_priority_req, periodic: in_periodic, ready: 1'b0};
                  count_r <= count_r + CW'(1);
                end
              end
              pts_pkg::ACT_DELETE: begin
                if (!enabled_r) status_r <= pts_pkg::ST_NOT_INIT;
                else if (in_task_id == '0) status_r <= pts_pkg::ST_NULL_ID;
                else state_r <= S_DEL;
              end
              pts_pkg::ACT_TICK: begin
                if (tick_r <= wrap_r && tick_r != 32'hFFFF_FFFF) tick_r <= tick_r + 32'd1;
                else tick_r <= 32'd1;
                state_r <= S_TICK_START;
              end
              default: state_r <= S_DISP;
            endcase
          end
        end
        S_DEL: begin
          // swap-with-last removal; moved entry is checked again
          if (idx_r >= count_r) state_r <= S_DONE;
          else if (table_r[idx].id == del_id_r) begin
            table_r[idx] <= table_r[last];
            count_r      <= count_r - CW'(1);
          end else idx_r <= idx_r + CW'(1);
        end
        S_TICK_START: begin
          if (idx_r >= count_r) state_r <= S_DONE;
          else if (table_r[idx].period == '0) idx_r <= idx_r + CW'(1);
          else state_r <= S_TICK_WAIT;
        end
        S_TICK_WAIT: begin
          if (mrsp.done) begin
            if (mrsp.zero_rem) table_r[idx].ready <= 1'b1;
            idx_r   <= idx_r + CW'(1);
            state_r <= S_TICK_START;
          end
        end
        S_DISP: begin
          if (idx_r >= count_r) begin
            if (found_r) begin
              run_valid_r <= 1'b1;
              run_id_r    <= table_r[best_r].id;
              if (table_r[best_r].periodic) begin
                table_r[best_r].ready <= 1'b0;
                state_r <= S_DONE;
              end else begin
                del_id_r <= table_r[best_r].id;
                idx_r    <= '0;
                state_r  <= S_DEL;
              end
            end else state_r <= S_DONE;
          end else begin
            if (table_r[idx].ready && (!found_r || table_r[idx].prio > best_prio_r)) begin
              found_r     <= 1'b1;
              best_r      <= idx;
              best_prio_r <= table_r[idx].prio;
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pts_pkg::REG_ENABLED:    cfg_prdata = {31'd0, enabled_r};
      pts_pkg::REG_MAX_PERIOD: cfg_prdata = {16'd0, max_period_r};
      pts_pkg::REG_WRAP_LIMIT: cfg_prdata = wrap_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  assign cfg_pready      = 1'b1;
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_run_valid   = run_valid_r;
  assign out_run_task_id = run_id_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("task count past depth");
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction not in flight");
  a_run_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_valid) |-> (out_run_task_id != '0 && out_status == pts_pkg::ST_OK))
    else $error("dispatch result inconsistent");
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
`endif

endmodule

FILE: src/pts_mod_unit.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
module pts_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::mod_req_t req,
  output pts_pkg::mod_rsp_t rsp
);

  logic [31:0] dvd_r, dvd_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] shifted;
  logic [16:0] diff;

  always_comb begin
    shifted  = {rem_r[15:0], dvd_r[31]};
    diff     = shifted - {1'b0, dvs_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      rem_nxt = diff[16] ? shifted : diff;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.zero_rem = (rem_r == '0);

endmodule

FILE: tb/pts_checker.sv
// checker: watches the scheduler channels, predicts results and compares them
`timescale 1ns / 1ps
module pts_checker #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_priority_req,
  input  logic        in_periodic,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic        out_run_valid,
  input  logic [7:0]  out_run_task_id,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0] status;
    logic       run_valid;
    logic [7:0] run_id;
  } sched_result_t;

  pts_pkg::slot_t tasks[TABLE_DEPTH];
  int            n_tasks;
  logic [31:0]   tick_cnt;
  logic          en_q;
  logic [15:0]   max_per_q;
  logic [31:0]   wrap_q;
  sched_result_t want_q[$];

  assign pending = want_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    fail_count++;
  endtask

  function automatic void drop_id(input logic [7:0] id);
    int i;
    i = 0;
    while (i < n_tasks) begin
      if (tasks[i].id == id) begin
        n_tasks--;
        tasks[i] = tasks[n_tasks];
      end else begin
        i++;
      end
    end
  endfunction

  function automatic sched_result_t schedule(input pts_pkg::action_t act,
                                             input logic [7:0] id,
                                             input logic [15:0] per, input logic [7:0] pr,
                                             input logic periodic);
    sched_result_t r;
    int best;
    r = '0;
    best = -1;
    case (act)
      pts_pkg::ACT_CREATE: begin
        if (!en_q) r.status = pts_pkg::ST_NOT_INIT;
        else if (id == 0) r.status = pts_pkg::ST_NULL_ID;
        else if (per > max_per_q) r.status = pts_pkg::ST_PERIOD;
        else if (n_tasks >= TABLE_DEPTH) r.status = pts_pkg::ST_FULL;
        else begin
          tasks[n_tasks] = '{id: id, period: per, prio: pr, periodic: periodic, ready: 1'b0};
          n_tasks++;
        end
      end
      pts_pkg::ACT_DELETE: begin
        if (!en_q) r.status = pts_pkg::ST_NOT_INIT;
        else if (id == 0) r.status = pts_pkg::ST_NULL_ID;
        else drop_id(id);
      end
      pts_pkg::ACT_TICK: begin
        if (tick_cnt <= wrap_q && tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
        else tick_cnt = 32'd1;
        for (int i = 0; i < n_tasks; i++)
          if (tasks[i].period != 0 && (tick_cnt % tasks[i].period) == 0) tasks[i].ready = 1'b1;
      end
      default: begin
        for (int i = 0; i < n_tasks; i++)
          if (tasks[i].ready && (best < 0 || tasks[i].prio > tasks[best].prio)) best = i;
        if (best >= 0) begin
          r.run_valid = 1'b1;
          r.run_id = tasks[best].id;
          if (tasks[best].periodic) tasks[best].ready = 1'b0;
          else drop_id(tasks[best].id);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst_n) begin
      n_tasks = 0;
      tick_cnt = 32'd1;
      en_q <= 1'b0;
      max_per_q <= 16'hFFFF;
      wrap_q <= 32'hFFFF_FFFE;
      want_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          pts_pkg::REG_ENABLED:    en_q <= cfg_pwdata[0];
          pts_pkg::REG_MAX_PERIOD: max_per_q <= cfg_pwdata[15:0];
          pts_pkg::REG_WRAP_LIMIT: wrap_q <= cfg_pwdata;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (want_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = want_q.pop_front();
          if (out_status !== e.status) report("status", out_status, e.status);
          if (out_run_valid !== e.run_valid) report("run_valid", out_run_valid, e.run_valid);
          if (out_run_task_id !== e.run_id) report("run_task_id", out_run_task_id, e.run_id);
        end
      end
      if (start && !busy)
        want_q.push_back(schedule(pts_pkg::action_t'(in_action), in_task_id, in_period,
                                  in_priority_req, in_periodic));
    end
  end

  initial fail_count = 0;

endmodule

FILE: tb/testbench.sv
// testbench top: stimulus, configuration writes and verdict for the scheduler
`timescale 1ns / 1ps
module testbench;

  localparam int  N_RANDOM   = 1265;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [7:0]  in_task_id;
  logic [15:0] in_period;
  logic [7:0]  in_priority_req;
  logic        in_periodic;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_run_valid;
  logic [7:0]  out_run_task_id;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  longint      cycles;
  bit          calm;

  priority_tick_task_scheduler_core i_dut (.*);

  pts_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  // wait for every outstanding transaction, then settle
  task automatic drain();
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic issue(input pts_pkg::action_t act, input logic [7:0] id,
                       input logic [15:0] per,
                       input logic [7:0] pr, input logic periodic);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    in_action = act; in_task_id = id; in_period = per;
    in_priority_req = pr; in_periodic = periodic;
    @(negedge clk);
    start = 1'b0;
    in_action = 2'($urandom); in_task_id = 8'($urandom);
    in_period = 16'($urandom); in_priority_req = 8'($urandom); in_periodic = 1'($urandom);
  endtask

  // mostly small periods so tasks become ready; some large ones
  task automatic random_item();
    logic [15:0] per;
    int sel;
    sel = $urandom_range(0, 99);
    per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    if (sel < 30)
      issue(pts_pkg::ACT_CREATE,
            ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
            per, 8'($urandom), 1'($urandom));
    else if (sel < 42) issue(pts_pkg::ACT_DELETE, 8'($urandom_range(0, 7)), 16'($urandom),
                             8'($urandom), 1'($urandom));
    else if (sel < 70) issue(pts_pkg::ACT_TICK, 8'($urandom), 16'($urandom), 8'($urandom),
                             1'($urandom));
    else issue(pts_pkg::ACT_DISPATCH, 8'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom));
  endtask

  initial begin
    start = 1'b0; in_action = pts_pkg::ACT_TICK; in_task_id = '0; in_period = '0;
    in_priority_req = '0; in_periodic = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    calm = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: disabled checks, then each create error, deletes, ticks, dispatch
    issue(pts_pkg::ACT_CREATE, 8'd5, 16'd1, 8'd1, 1'b1);
    issue(pts_pkg::ACT_DELETE, 8'd5, 16'd0, 8'd0, 1'b0);
    issue(pts_pkg::ACT_DISPATCH, 8'd0, 16'd0, 8'd0, 1'b0);
    drain();
    reg_write(pts_pkg::REG_ENABLED, 32'd1);
    reg_write(pts_pkg::REG_MAX_PERIOD, 32'd100);
    reg_write(pts_pkg::REG_WRAP_LIMIT, 32'd3);
    issue(pts_pkg::ACT_CREATE, 8'd0, 16'd1, 8'd1, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd9, 16'd101, 8'd1, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'hFF, 16'd100, 8'hFF, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd1, 16'd0, 8'd7, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd2, 16'd2, 8'd7, 1'b0);
    issue(pts_pkg::ACT_CREATE, 8'd2, 16'd1, 8'd3, 1'b0);
    issue(pts_pkg::ACT_CREATE, 8'd3, 16'd1, 8'd7, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd4, 16'd1, 8'd0, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd6, 16'd3, 8'd9, 1'b1);
    issue(pts_pkg::ACT_CREATE, 8'd7, 16'd1, 8'd9, 1'b0);
    issue(pts_pkg::ACT_CREATE, 8'd8, 16'd1, 8'd9, 1'b0);
    issue(pts_pkg::ACT_DELETE, 8'd0, 16'd0, 8'd0, 1'b0);
    issue(pts_pkg::ACT_DELETE, 8'd77, 16'd0, 8'd0, 1'b0);
    for (int k = 0; k < 5; k++) issue(pts_pkg::ACT_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
    for (int k = 0; k < 4; k++) issue(pts_pkg::ACT_DISPATCH, 8'd0, 16'd0, 8'd0, 1'b0);
    issue(pts_pkg::ACT_DELETE, 8'd2, 16'd0, 8'd0, 1'b0);
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(pts_pkg::REG_MAX_PERIOD, 32'hFFFF);
                 reg_write(pts_pkg::REG_WRAP_LIMIT, 32'hFFFF_FFFE); end
        1: begin reg_write(pts_pkg::REG_MAX_PERIOD, 32'd0);
                 reg_write(pts_pkg::REG_WRAP_LIMIT, 32'd1); end
        2: begin reg_write(pts_pkg::REG_MAX_PERIOD, 32'd4);
                 reg_write(pts_pkg::REG_WRAP_LIMIT, 32'd12); end
        3: begin reg_write(pts_pkg::REG_ENABLED, 32'd0); end
        4: begin reg_write(pts_pkg::REG_ENABLED, 32'hFFFF_FFFF);
                 reg_write(pts_pkg::REG_MAX_PERIOD, 32'($urandom));
                 reg_write(pts_pkg::REG_WRAP_LIMIT, 32'($urandom_range(1, 60))); end
        default: begin reg_write(pts_pkg::REG_MAX_PERIOD, 32'hFFFF);
                       reg_write(pts_pkg::REG_WRAP_LIMIT, 32'd30); end
      endcase
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < ((ph == 3) ? 60 : N_RANDOM / 5); k++) random_item();
      drain();
    end

    drain();
    repeat (400) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pts_pkg.sv
src/pts_mod_unit.sv
src/priority_tick_task_scheduler_core.sv
tb/pts_checker.sv
tb/testbench.sv
